[sv/glos_pkg.sv]
// Shared types and constants of the grid line-of-sight block.
package glos_pkg;

	localparam int DEF_GRID_COLUMNS = 64;
	localparam int DEF_GRID_ROWS    = 64;

	// Coordinate width fixed by the request fields.
	localparam int COORD_W = 7;
	// Crossing sums: |d| * (1 + 2 * steps) with |d| <= 63, steps <= 126.
	localparam int SUM_W   = 14;
	// Step counter and walk bound.
	localparam int CNT_W   = 8;

	// Which cell the map read port probes.
	typedef enum logic [2:0] {
		RD_START,
		RD_GOAL,
		RD_NEXT,
		RD_SIDE_COL,
		RD_SIDE_ROW
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		rd_sel_t rd_sel;
		logic    move;
		logic    wr_en;
	} glos_cmd_t;

	typedef struct packed {
		logic start_in_grid;
		logic goal_in_grid;
		logic probe_blocked;
		logic same_ends;
		logic at_goal;
		logic tie;
		logic step_limit;
	} glos_sts_t;

endpackage

[sv/glos_datapath.sv]
// Datapath: occupancy map, walk position, crossing sums and probe read.
module glos_datapath #(
	parameter int GRID_COLUMNS = glos_pkg::DEF_GRID_COLUMNS,
	parameter int GRID_ROWS    = glos_pkg::DEF_GRID_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  glos_pkg::glos_cmd_t           cmd,
	output glos_pkg::glos_sts_t           sts,
	input  logic [glos_pkg::COORD_W-1:0]  start_column,
	input  logic [glos_pkg::COORD_W-1:0]  start_row,
	input  logic [glos_pkg::COORD_W-1:0]  goal_column,
	input  logic [glos_pkg::COORD_W-1:0]  goal_row,
	input  logic                          cell_blocked
);

	localparam int COL_W = $clog2(GRID_COLUMNS);
	localparam int ROW_W = $clog2(GRID_ROWS);
	localparam logic [glos_pkg::COORD_W-1:0] COL_LIM = glos_pkg::COORD_W'(GRID_COLUMNS);
	localparam logic [glos_pkg::COORD_W-1:0] ROW_LIM = glos_pkg::COORD_W'(GRID_ROWS);

	// one row of the map per word; a row reads as free until first written
	logic [GRID_COLUMNS-1:0] mem [GRID_ROWS];
	logic [GRID_ROWS-1:0]    row_valid_q;

	logic [glos_pkg::COORD_W-1:0] c0_q, r0_q, c1_q, r1_q;
	logic [glos_pkg::COORD_W-1:0] col_q, row_q, adc_q, adr_q;
	logic                         col_up_q, row_up_q, blk_q;
	logic [glos_pkg::SUM_W-1:0]   col_sum_q, row_sum_q;
	logic [glos_pkg::CNT_W-1:0]   steps_q, limit_q;

	logic [GRID_COLUMNS-1:0] rd_word_q;
	logic                    rd_valid_q;
	logic [COL_W-1:0]        rd_col_q;
	logic                    rd_oob_q;

	logic                         in_col_up, in_row_up;
	logic [glos_pkg::COORD_W-1:0] in_adc, in_adr;

	logic                         has_col, has_row, take_col, take_row;
	logic [glos_pkg::COORD_W-1:0] nc, nr, next_col, next_row;
	logic [glos_pkg::COORD_W-1:0] rc, rr;
	logic                         rd_oob;
	logic [GRID_COLUMNS-1:0]      wr_word;

	// request decode at load
	assign in_col_up = goal_column > start_column;
	assign in_row_up = goal_row > start_row;
	assign in_adc    = in_col_up ? goal_column - start_column : start_column - goal_column;
	assign in_adr    = in_row_up ? goal_row - start_row : start_row - goal_row;

	// step decision: exact compare of next boundary crossings
	assign has_col  = adc_q != '0;
	assign has_row  = adr_q != '0;
	assign take_col = has_col && (!has_row || col_sum_q <= row_sum_q);
	assign take_row = has_row && (!has_col || row_sum_q <= col_sum_q);
	assign nc       = col_up_q ? col_q + 1'b1 : col_q - 1'b1;
	assign nr       = row_up_q ? row_q + 1'b1 : row_q - 1'b1;
	assign next_col = take_col ? nc : col_q;
	assign next_row = take_row ? nr : row_q;

	always_comb begin
		unique case (cmd.rd_sel)
			glos_pkg::RD_START: begin
				rc = c0_q;
				rr = r0_q;
			end
			glos_pkg::RD_GOAL: begin
				rc = c1_q;
				rr = r1_q;
			end
			glos_pkg::RD_NEXT: begin
				rc = next_col;
				rr = next_row;
			end
			glos_pkg::RD_SIDE_COL: begin
				rc = nc;
				rr = row_q;
			end
			glos_pkg::RD_SIDE_ROW: begin
				rc = col_q;
				rr = nr;
			end
			default: begin
				rc = c0_q;
				rr = r0_q;
			end
		endcase
	end

	// wrapped or past-the-edge coordinates read as blocked
	assign rd_oob = !(rc < COL_LIM && rr < ROW_LIM);

	// write merges one bit into the row read in the previous cycle
	always_comb begin
		wr_word = rd_valid_q ? rd_word_q : '0;
		wr_word[c0_q[COL_W-1:0]] = blk_q;
	end

	always_ff @(posedge clk) begin
		rd_word_q  <= mem[rr[ROW_W-1:0]];
		rd_valid_q <= row_valid_q[rr[ROW_W-1:0]];
		rd_col_q   <= rc[COL_W-1:0];
		rd_oob_q   <= rd_oob;
		if (cmd.wr_en) begin
			mem[r0_q[ROW_W-1:0]] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (cmd.wr_en) begin
			row_valid_q[r0_q[ROW_W-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c0_q      <= start_column;
			r0_q      <= start_row;
			c1_q      <= goal_column;
			r1_q      <= goal_row;
			blk_q     <= cell_blocked;
			col_q     <= start_column;
			row_q     <= start_row;
			col_up_q  <= in_col_up;
			row_up_q  <= in_row_up;
			adc_q     <= in_adc;
			adr_q     <= in_adr;
			col_sum_q <= glos_pkg::SUM_W'(in_adr);
			row_sum_q <= glos_pkg::SUM_W'(in_adc);
			steps_q   <= '0;
			limit_q   <= glos_pkg::CNT_W'(in_adc) + glos_pkg::CNT_W'(in_adr);
		end else if (cmd.move) begin
			col_q   <= next_col;
			row_q   <= next_row;
			steps_q <= steps_q + 1'b1;
			if (take_col) begin
				col_sum_q <= col_sum_q + glos_pkg::SUM_W'({adr_q, 1'b0});
			end
			if (take_row) begin
				row_sum_q <= row_sum_q + glos_pkg::SUM_W'({adc_q, 1'b0});
			end
		end
	end

	assign sts.start_in_grid = c0_q < COL_LIM && r0_q < ROW_LIM;
	assign sts.goal_in_grid  = c1_q < COL_LIM && r1_q < ROW_LIM;
	assign sts.probe_blocked = rd_oob_q | (rd_valid_q & rd_word_q[rd_col_q]);
	assign sts.same_ends     = c0_q == c1_q && r0_q == r1_q;
	assign sts.at_goal       = col_q == c1_q && row_q == r1_q;
	assign sts.tie           = has_col && has_row && col_sum_q == row_sum_q;
	assign sts.step_limit    = steps_q == limit_q;

	a_move_advances: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |-> (take_col || take_row))
		else $error("walk step moves neither column nor row");

	a_move_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |-> steps_q < limit_q)
		else $error("walk step past the step bound");

endmodule

[sv/glos_ctrl.sv]
// Controller: sequences map writes, endpoint checks and the cell walk.
module glos_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                operation,
	output logic                busy,
	output logic                done,
	output logic                visible,
	output glos_pkg::glos_cmd_t cmd,
	input  glos_pkg::glos_sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WR_CHECK,
		S_WR_BACK,
		S_Q_START,
		S_Q_GOAL,
		S_Q_ENDS,
		S_WALK,
		S_TIE_ROW,
		S_TIE_MOVE
	} state_t;

	state_t state_q, state_d;
	logic   done_q, visible_q;
	logic   fin, fin_val;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.rd_sel = glos_pkg::RD_NEXT;
		cmd.move   = 1'b0;
		cmd.wr_en  = 1'b0;
		fin        = 1'b0;
		fin_val    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = operation ? S_Q_START : S_WR_CHECK;
				end
			end
			S_WR_CHECK: begin
				cmd.rd_sel = glos_pkg::RD_START;
				state_d    = sts.start_in_grid ? S_WR_BACK : S_IDLE;
			end
			S_WR_BACK: begin
				cmd.wr_en = 1'b1;
				state_d   = S_IDLE;
			end
			S_Q_START: begin
				cmd.rd_sel = glos_pkg::RD_START;
				if (!(sts.start_in_grid && sts.goal_in_grid)) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_Q_GOAL;
				end
			end
			S_Q_GOAL: begin
				cmd.rd_sel = glos_pkg::RD_GOAL;
				if (sts.probe_blocked) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_Q_ENDS;
				end
			end
			S_Q_ENDS, S_WALK: begin
				// S_Q_ENDS checks the goal read, S_WALK the cell just entered
				priority if (sts.probe_blocked) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else if (state_q == S_Q_ENDS ? sts.same_ends : sts.at_goal) begin
					fin     = 1'b1;
					fin_val = 1'b1;
					state_d = S_IDLE;
				end else if (state_q == S_WALK && sts.step_limit) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else if (sts.tie) begin
					cmd.rd_sel = glos_pkg::RD_SIDE_COL;
					state_d    = S_TIE_ROW;
				end else begin
					cmd.move   = 1'b1;
					cmd.rd_sel = glos_pkg::RD_NEXT;
					state_d    = S_WALK;
				end
			end
			S_TIE_ROW: begin
				cmd.rd_sel = glos_pkg::RD_SIDE_ROW;
				if (sts.probe_blocked) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_TIE_MOVE;
				end
			end
			S_TIE_MOVE: begin
				if (sts.probe_blocked) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.move   = 1'b1;
					cmd.rd_sel = glos_pkg::RD_NEXT;
					state_d    = S_WALK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			visible_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (fin) begin
				visible_q <= fin_val;
			end
		end
	end

	assign busy    = state_q != S_IDLE;
	assign done    = done_q;
	assign visible = visible_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

endmodule

[sv/grid_line_of_sight.sv]
// Top level of the grid line-of-sight block: controller plus datapath.
//
// A request is taken on a rising edge with start high and busy low. A write
// (operation 0) sets or clears one map cell if that cell lies inside the
// grid and is dropped otherwise; it gives no result. A query (operation 1)
// answers with done high for exactly one cycle and visible valid in that
// cycle; the receiver cannot hold it off, so it must take the result then.
// A query first runs the endpoint checks, then reads one cell for each
// cell entered along the walk, plus the two side neighbors before each
// diagonal tie step. A corner-to-corner diagonal on a 64 by 64 grid is
// the worst case, with 63 tie steps. The query time is set by the map's
// single read port: one row read per probed cell. The map is held as one
// word per grid row with a valid bit per row, so it reads all free right
// after reset with no clearing pass.
module grid_line_of_sight #(
	parameter int GRID_COLUMNS = glos_pkg::DEF_GRID_COLUMNS,
	parameter int GRID_ROWS    = glos_pkg::DEF_GRID_ROWS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic [glos_pkg::COORD_W-1:0] start_column,
	input  logic [glos_pkg::COORD_W-1:0] start_row,
	input  logic [glos_pkg::COORD_W-1:0] goal_column,
	input  logic [glos_pkg::COORD_W-1:0] goal_row,
	input  logic                         cell_blocked,
	output logic                         done,
	output logic                         visible
);

	// command and status between controller and datapath
	glos_pkg::glos_cmd_t cmd;
	glos_pkg::glos_sts_t sts;

	// sequencer: write read-modify-write, endpoint checks, walk steps
	glos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.busy      (busy),
		.done      (done),
		.visible   (visible),
		.cmd       (cmd),
		.sts       (sts)
	);

	// map storage, position and crossing sums
	glos_datapath #(
		.GRID_COLUMNS (GRID_COLUMNS),
		.GRID_ROWS    (GRID_ROWS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.start_column (start_column),
		.start_row    (start_row),
		.goal_column  (goal_column),
		.goal_row     (goal_row),
		.cell_blocked (cell_blocked)
	);

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the grid line-of-sight block.
`timescale 1ns / 100ps

module tb_top;

	localparam int  COLS        = glos_pkg::DEF_GRID_COLUMNS;
	localparam int  ROWS        = glos_pkg::DEF_GRID_ROWS;
	localparam int  CELLS       = COLS * ROWS;
	localparam bit  OP_WRITE    = 1'b0;
	localparam bit  OP_QUERY    = 1'b1;
	localparam int  RAND_ITEMS  = 600;
	localparam int  TAIL_CYCLES = 300;        // longer than the slowest query
	localparam int  CYCLE_LIMIT = 1_000_000;  // bound for the watchdog below
	localparam int  REPORT_MAX  = 10;

	typedef logic [glos_pkg::COORD_W-1:0] coord_t;

	// Holds a private copy of the occupancy map and the visibility bits
	// that queries in flight are due to return.
	class los_scoreboard;
		bit occupied [CELLS];
		bit visibility_q [$];
		int error_count;
		int write_count;
		int query_count;
		int clear_count;

		function new();
			error_count = 0;
			write_count = 0;
			query_count = 0;
			clear_count = 0;
			foreach (occupied[i])
				occupied[i] = 1'b0;
		endfunction

		function int pending();
			return visibility_q.size();
		endfunction

		// Off-grid cells count as blocked; a step below zero lands at -1.
		function bit blocked_at(int c, int r);
			if (c < 0 || c >= COLS || r < 0 || r >= ROWS)
				return 1'b1;
			return occupied[r * COLS + c];
		endfunction

		// Supercover walk with exact crossing sums; a tie goes diagonal only
		// when both side cells are free.
		function bit sight_clear(int c0, int r0, int c1, int r1);
			int col, row, adc, adr, cdir, rdir, col_sum, row_sum, nc, nr;
			bit take_c, take_r;
			if (c0 >= COLS || r0 >= ROWS || c1 >= COLS || r1 >= ROWS)
				return 1'b0;
			if (blocked_at(c0, r0) || blocked_at(c1, r1))
				return 1'b0;
			if (c0 == c1 && r0 == r1)
				return 1'b1;
			cdir    = (c1 > c0) ? 1 : -1;
			rdir    = (r1 > r0) ? 1 : -1;
			adc     = (c1 > c0) ? c1 - c0 : c0 - c1;
			adr     = (r1 > r0) ? r1 - r0 : r0 - r1;
			col     = c0;
			row     = r0;
			col_sum = adr;
			row_sum = adc;
			for (int s = 0; s < adc + adr; s++) begin
				nc = col + cdir;
				nr = row + rdir;
				if (adc == 0) begin
					take_c = 1'b0; take_r = 1'b1;
				end else if (adr == 0) begin
					take_c = 1'b1; take_r = 1'b0;
				end else if (col_sum < row_sum) begin
					take_c = 1'b1; take_r = 1'b0;
				end else if (row_sum < col_sum) begin
					take_c = 1'b0; take_r = 1'b1;
				end else begin
					if (blocked_at(nc, row) || blocked_at(col, nr))
						return 1'b0;
					take_c = 1'b1; take_r = 1'b1;
				end
				if (take_c) begin
					col     = nc;
					col_sum = col_sum + 2 * adr;
				end
				if (take_r) begin
					row     = nr;
					row_sum = row_sum + 2 * adc;
				end
				if (blocked_at(col, row))
					return 1'b0;
				if (col == c1 && row == r1)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_request(bit op, coord_t sc, coord_t sr, coord_t gc,
				coord_t gr, bit blk);
			bit vis;
			if (op == OP_WRITE) begin
				write_count++;
				if (sc < COLS && sr < ROWS)
					occupied[sr * COLS + sc] = blk;
			end else begin
				query_count++;
				vis = sight_clear(sc, sr, gc, gr);
				if (vis)
					clear_count++;
				visibility_q = {visibility_q, vis};
			end
		endfunction

		function void check_result(bit vis);
			bit want;
			if (visibility_q.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_MAX)
					$display("%0t: result with no query pending, visible=%0b",
						$realtime, vis);
				return;
			end
			want = visibility_q.pop_front();
			if (vis !== want) begin
				error_count++;
				if (error_count <= REPORT_MAX)
					$display("%0t: visible mismatch, expected %0b got %0b",
						$realtime, want, vis);
			end
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	logic   operation;
	coord_t start_column;
	coord_t start_row;
	coord_t goal_column;
	coord_t goal_row;
	logic   cell_blocked;
	logic   done;
	logic   visible;

	los_scoreboard sb;
	int            cycle_count;
	int            win_col;
	int            win_row;
	bit            idle_on;

	grid_line_of_sight DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.start_column (start_column),
		.start_row    (start_row),
		.goal_column  (goal_column),
		.goal_row     (goal_row),
		.cell_blocked (cell_blocked),
		.done         (done),
		.visible      (visible)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Results cannot be held off: every done cycle is taken here.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(visible);
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d results outstanding",
			cycle_count, sb.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Present one request at the falling edge and hold it until the rising
	// edge that sees busy low. Start stays high on return, so back-to-back
	// requests keep it high without a glitch.
	task automatic issue_request(bit op, coord_t sc, coord_t sr, coord_t gc,
			coord_t gr, bit blk);
		@(negedge clk);
		start        <= 1'b1;
		operation    <= op;
		start_column <= sc;
		start_row    <= sr;
		goal_column  <= gc;
		goal_row     <= gr;
		cell_blocked <= blk;
		do
			@(posedge clk);
		while (busy);
		sb.note_request(op, sc, sr, gc, gr, blk);
	endtask

	task automatic query(int sc, int sr, int gc, int gr);
		issue_request(OP_QUERY, coord_t'(sc), coord_t'(sr), coord_t'(gc),
			coord_t'(gr), 1'b0);
	endtask

	task automatic map_write(int c, int r, bit blk);
		issue_request(OP_WRITE, coord_t'(c), coord_t'(r), coord_t'($urandom),
			coord_t'($urandom), blk);
	endtask

	task automatic sender_idle(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Hold off until every query in flight has answered.
	task automatic drain_results();
		sender_idle(1);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Coordinates: some anywhere in 0..127, many inside a 16x16 window
	// so that the window fills up with blocked cells, the rest in grid.
	function automatic coord_t pick_coord(int base);
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return coord_t'($urandom_range(127));
		else if (r < 60)
			return coord_t'(base + $urandom_range(15));
		else
			return coord_t'($urandom_range(63));
	endfunction

	task automatic random_request();
		coord_t sc, sr, gc, gr;
		int     k, m;
		sc = pick_coord(win_col);
		sr = pick_coord(win_row);
		if ($urandom_range(99) < 35) begin
			issue_request(OP_WRITE, sc, sr, coord_t'($urandom), coord_t'($urandom),
				$urandom_range(99) < 45);
		end else begin
			if ($urandom_range(99) < 25) begin
				// slopes 1 and 3 put ties on the walk
				k  = $urandom_range(1, 20);
				m  = $urandom_range(1) ? 1 : 3;
				gc = $urandom_range(1) ? coord_t'(sc + k) : coord_t'(sc - k);
				gr = $urandom_range(1) ? coord_t'(sr + k * m) : coord_t'(sr - k * m);
				if ($urandom_range(1)) begin
					{gc, gr} = {gr, gc};
					{sc, sr} = {sr, sc};
				end
			end else begin
				gc = pick_coord(win_col);
				gr = pick_coord(win_row);
			end
			issue_request(OP_QUERY, sc, sr, gc, gr, 1'b0);
		end
	endtask

	initial begin
		sb           = new();
		arst_n       = 1'b0;
		start        = 1'b0;
		operation    = OP_WRITE;
		start_column = '0;
		start_row    = '0;
		goal_column  = '0;
		goal_row     = '0;
		cell_blocked = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// --- directed ---
		query(0, 0, 63, 63);       // longest diagonal on the empty map
		query(0, 63, 63, 0);
		query(7, 9, 7, 9);         // equal endpoints
		query(64, 0, 0, 0);        // start off grid
		query(0, 0, 0, 127);       // goal off grid
		query(127, 127, 127, 127); // equal but off grid
		map_write(100, 5, 1'b1);   // off-grid writes are dropped
		map_write(5, 100, 1'b1);
		query(0, 5, 63, 5);
		map_write(10, 10, 1'b1);
		query(10, 10, 20, 20);     // blocked start
		query(20, 20, 10, 10);     // blocked goal
		query(10, 10, 10, 10);     // equal endpoints, blocked
		query(0, 10, 63, 10);      // row through blocked cell
		query(10, 0, 10, 63);      // column through blocked cell
		query(5, 0, 8, 1);
		map_write(31, 30, 1'b1);   // side cell of a diagonal tie
		query(30, 30, 32, 32);
		query(32, 32, 30, 30);
		map_write(31, 30, 1'b0);
		query(30, 30, 32, 32);
		map_write(63, 63, 1'b1);
		query(0, 0, 63, 63);
		map_write(63, 63, 1'b0);
		drain_results();

		// --- random ---
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 100 == 0) begin
				win_col = $urandom_range(48);
				win_row = $urandom_range(48);
			end
			if (i == 300 || i == 450)
				drain_results();
			idle_on = (i < 200 || i >= 350);
			if (idle_on && $urandom_range(99) < 13)
				sender_idle($urandom_range(1, 4));
			random_request();
		end
		sender_idle(1);

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d map writes and %0d queries (%0d clear, %0d blocked),",
			sb.write_count, sb.query_count, sb.clear_count,
			sb.query_count - sb.clear_count);
		$display("including off-grid ends, blocked ends and diagonal ties; %0d errors",
			sb.error_count);
		if (sb.error_count == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
